>>> src/qspm_pkg.sv
// Shared types and constants for the query slot position mapper.
// No dependencies.
`timescale 1ns / 1ps
package qspm_pkg;
   localparam int MAX_DIMS_DEF   = 3;
   localparam int INDEX_BITS_DEF = 32;
   localparam int SLOT_BITS_DEF  = 14;

   localparam int SIZE_BITS = 16;
   localparam int GAP_BITS  = 15;
   localparam int CFG_BITS  = 32;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIM_COUNT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_SIZE  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SECOND_SIZE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THIRD_SIZE  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ENTRY_COUNT = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOT_GAP    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROW_SLOTS   = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEFAULT_IDX = 3'd7;

   localparam logic [1:0] DIMS_THREE = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_COORD = 2'd2;

   localparam logic [1:0]           RST_DIM_COUNT   = 2'd2;
   localparam logic [SIZE_BITS-1:0] RST_FIRST_SIZE  = 16'd64;
   localparam logic [SIZE_BITS-1:0] RST_SECOND_SIZE = 16'd64;
   localparam logic [SIZE_BITS-1:0] RST_THIRD_SIZE  = 16'd1;
   localparam logic [CFG_BITS-1:0]  RST_ENTRY_COUNT = 32'd4096;
   localparam logic [GAP_BITS-1:0]  RST_SLOT_GAP    = 15'd64;
   localparam logic [GAP_BITS-1:0]  RST_ROW_SLOTS   = 15'd4096;
   localparam logic [CFG_BITS-1:0]  RST_DEFAULT_IDX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic       dims3;
      logic       skip;
      logic [1:0] err;
   } flags_type;
endpackage

>>> src/qspm_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a divisor.
// Carries a valid bit and a sideband word alongside; no package dependencies.
`timescale 1ns / 1ps
module qspm_div #(
   parameter int NW    = 32,
   parameter int DW    = 16,
   parameter int LANES = 1,
   parameter int SW    = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_vld,
   input  logic [LANES-1:0][NW-1:0]       in_num,
   input  logic [DW-1:0]                  in_den,
   input  logic [SW-1:0]                  in_side,
   output logic                           out_vld,
   output logic [LANES-1:0][NW-1:0]       out_quo,
   output logic [LANES-1:0][DW-1:0]       out_rem,
   output logic [SW-1:0]                  out_side
);
   logic                     vld_ff  [NW];
   logic [DW-1:0]            den_ff  [NW];
   logic [SW-1:0]            side_ff [NW];
   logic [LANES-1:0][NW-1:0] num_ff  [NW];
   logic [LANES-1:0][DW-1:0] rem_ff  [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic                     v_cur;
      logic [DW-1:0]            d_cur;
      logic [SW-1:0]            s_cur;
      logic [LANES-1:0][NW-1:0] n_cur;
      logic [LANES-1:0][DW-1:0] r_cur;
      logic [LANES-1:0][NW-1:0] n_in;
      logic [LANES-1:0][DW-1:0] r_in;

      if (k == 0) begin : g_first
         assign v_cur = in_vld;
         assign d_cur = in_den;
         assign s_cur = in_side;
         assign n_cur = in_num;
         assign r_cur = '0;
      end else begin : g_next
         assign v_cur = vld_ff[k-1];
         assign d_cur = den_ff[k-1];
         assign s_cur = side_ff[k-1];
         assign n_cur = num_ff[k-1];
         assign r_cur = rem_ff[k-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DW:0] trial;
         logic        fits;
         assign trial = {r_cur[l], n_cur[l][NW-1]};
         assign fits  = (trial >= {1'b0, d_cur});
         assign r_in[l] = fits ? DW'(trial - {1'b0, d_cur}) : trial[DW-1:0];
         assign n_in[l] = {n_cur[l][NW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= v_cur;
         end
         den_ff[k]  <= d_cur;
         side_ff[k] <= s_cur;
         num_ff[k]  <= n_in;
         rem_ff[k]  <= r_in;
      end
   end

   assign out_vld  = vld_ff[NW-1];
   assign out_quo  = num_ff[NW-1];
   assign out_rem  = rem_ff[NW-1];
   assign out_side = side_ff[NW-1];
endmodule

>>> src/query_slot_position_mapper.sv
// Top level of the query slot position mapper: configuration registers, checks and result output.
// Depends on qspm_pkg and qspm_div.
`timescale 1ns / 1ps
// A new word is taken only while busy is low: busy stays high after each start for the
// time the result port needs to send up to three results of one word. Results of a word
// pass through five chained bit-per-stage dividers and four register stages and then
// appear on consecutive cycles, the final one marked by
// rsp_last. The result port has no back-pressure; the receiver must take every strobe.
module query_slot_position_mapper
   import qspm_pkg::*;
#(
   parameter int MAX_DIMS   = MAX_DIMS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF,
   parameter int SLOT_BITS  = SLOT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [INDEX_BITS-1:0]   req_entry_index,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_dim_number,
   output logic [SLOT_BITS-1:0]    rsp_slot_position,
   output logic [SIZE_BITS-1:0]    rsp_entry_slot,
   output logic                    rsp_skipped,
   output logic [1:0]              rsp_error_code,
   output logic                    rsp_last,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);
   localparam int CW = (INDEX_BITS > CFG_BITS) ? INDEX_BITS : CFG_BITS;
   localparam int SUM_BITS = SIZE_BITS + 1;
   localparam int PROD_BITS = SIZE_BITS + GAP_BITS;

   logic [1:0]           dim_count_ff;
   logic [SIZE_BITS-1:0] size0_ff, size1_ff, size2_ff;
   logic [CFG_BITS-1:0]  entry_count_ff, default_idx_ff;
   logic [GAP_BITS-1:0]  slot_gap_ff, row_slots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff   <= RST_DIM_COUNT;
         size0_ff       <= RST_FIRST_SIZE;
         size1_ff       <= RST_SECOND_SIZE;
         size2_ff       <= RST_THIRD_SIZE;
         entry_count_ff <= RST_ENTRY_COUNT;
         slot_gap_ff    <= RST_SLOT_GAP;
         row_slots_ff   <= RST_ROW_SLOTS;
         default_idx_ff <= RST_DEFAULT_IDX;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIM_COUNT:   dim_count_ff   <= csr_wdata[1:0];
            CSR_FIRST_SIZE:  size0_ff       <= csr_wdata[SIZE_BITS-1:0];
            CSR_SECOND_SIZE: size1_ff       <= csr_wdata[SIZE_BITS-1:0];
            CSR_THIRD_SIZE:  size2_ff       <= csr_wdata[SIZE_BITS-1:0];
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata;
            CSR_SLOT_GAP:    slot_gap_ff    <= csr_wdata[GAP_BITS-1:0];
            CSR_ROW_SLOTS:   row_slots_ff   <= csr_wdata[GAP_BITS-1:0];
            CSR_DEFAULT_IDX: default_idx_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // accept and pace
   logic [1:0]            cool_ff, cool_in;
   logic                  a_vld_ff;
   logic [INDEX_BITS-1:0] a_idx_ff;
   logic                  accept;

   assign busy   = (cool_ff != 2'd0);
   assign accept = start && !busy;
   assign cool_in = accept ? 2'd2 : (busy ? cool_ff - 2'd1 : 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cool_ff  <= 2'd0;
         a_vld_ff <= 1'b0;
      end else begin
         cool_ff  <= cool_in;
         a_vld_ff <= accept;
      end
      a_idx_ff <= req_entry_index;
   end

   // checks
   logic      dims3;
   flags_type a_flags;
   logic [CW-1:0] idx_ext;

   assign dims3   = (MAX_DIMS >= 3) && (dim_count_ff == DIMS_THREE);
   assign idx_ext = CW'(a_idx_ff);

   always_comb begin
      a_flags.dims3 = dims3;
      a_flags.skip  = 1'b0;
      a_flags.err   = ERR_NONE;
      if (idx_ext == CW'(default_idx_ff)) begin
         a_flags.skip = 1'b1;
      end else if (idx_ext >= CW'(entry_count_ff)) begin
         a_flags.err = ERR_RANGE;
      end else if (size0_ff == '0 || size1_ff == '0 || (dims3 && size2_ff == '0)) begin
         a_flags.err = ERR_COORD;
      end
   end

   // index / size0
   logic                  d1_vld;
   logic [INDEX_BITS-1:0] d1_quo;
   logic [SIZE_BITS-1:0]  d1_rem;
   flags_type             d1_flags;

   qspm_div #(.NW(INDEX_BITS), .DW(SIZE_BITS), .LANES(1), .SW($bits(flags_type))) u_div_c0 (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (a_vld_ff),
      .in_num   (a_idx_ff),
      .in_den   (size0_ff),
      .in_side  (a_flags),
      .out_vld  (d1_vld),
      .out_quo  (d1_quo),
      .out_rem  (d1_rem),
      .out_side (d1_flags)
   );

   // quotient / size1
   logic                  d2_vld;
   logic [INDEX_BITS-1:0] d2_quo;
   logic [SIZE_BITS-1:0]  d2_rem;
   logic [SIZE_BITS-1:0]  d2_c0;
   flags_type             d2_flags;

   qspm_div #(.NW(INDEX_BITS), .DW(SIZE_BITS), .LANES(1),
              .SW(SIZE_BITS + $bits(flags_type))) u_div_c1 (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (d1_vld),
      .in_num   (d1_quo),
      .in_den   (size1_ff),
      .in_side  ({d1_rem, d1_flags}),
      .out_vld  (d2_vld),
      .out_quo  (d2_quo),
      .out_rem  (d2_rem),
      .out_side ({d2_c0, d2_flags})
   );

   // coordinate check
   flags_type            b_flags_in, b_flags_ff;
   logic                 b_vld_ff;
   logic [SIZE_BITS-1:0] b_c0_ff, b_c1_ff, b_c2_ff;

   always_comb begin
      b_flags_in = d2_flags;
      if (d2_flags.err == ERR_NONE && !d2_flags.skip) begin
         if (d2_flags.dims3 ? (CW'(d2_quo) >= CW'(size2_ff)) : (d2_quo != '0)) begin
            b_flags_in.err = ERR_COORD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= d2_vld;
      end
      b_flags_ff <= b_flags_in;
      b_c0_ff    <= d2_c0;
      b_c1_ff    <= d2_rem;
      b_c2_ff    <= SIZE_BITS'(d2_quo);
   end

   // running slot after dimension one
   logic                 d3_vld;
   logic [SUM_BITS-1:0]  d3_quo;
   logic [SIZE_BITS-1:0] d3_rem, d3_c0, d3_c2;
   flags_type            d3_flags;

   qspm_div #(.NW(SUM_BITS), .DW(SIZE_BITS), .LANES(1),
              .SW(2 * SIZE_BITS + $bits(flags_type))) u_div_cur1 (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (b_vld_ff),
      .in_num   ({1'b0, b_c0_ff} + {1'b0, b_c1_ff}),
      .in_den   (size0_ff),
      .in_side  ({b_c0_ff, b_c2_ff, b_flags_ff}),
      .out_vld  (d3_vld),
      .out_quo  (d3_quo),
      .out_rem  (d3_rem),
      .out_side ({d3_c0, d3_c2, d3_flags})
   );

   // running slot after dimension two
   logic                 d4_vld;
   logic [SUM_BITS-1:0]  d4_quo;
   logic [SIZE_BITS-1:0] d4_rem, d4_c0, d4_cur1;
   flags_type            d4_flags;

   qspm_div #(.NW(SUM_BITS), .DW(SIZE_BITS), .LANES(1),
              .SW(2 * SIZE_BITS + $bits(flags_type))) u_div_cur2 (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (d3_vld),
      .in_num   ({1'b0, d3_rem} + {1'b0, d3_c2}),
      .in_den   (size0_ff),
      .in_side  ({d3_c0, d3_rem, d3_flags}),
      .out_vld  (d4_vld),
      .out_quo  (d4_quo),
      .out_rem  (d4_rem),
      .out_side ({d4_c0, d4_cur1, d4_flags})
   );

   // slot products
   logic                                 c_vld_ff;
   logic [2:0][PROD_BITS-1:0]            c_prod_ff;
   logic [2:0][SIZE_BITS-1:0]            c_cur_ff;
   flags_type                            c_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= d4_vld;
      end
      c_prod_ff[0] <= PROD_BITS'(d4_c0) * PROD_BITS'(slot_gap_ff);
      c_prod_ff[1] <= PROD_BITS'(d4_cur1) * PROD_BITS'(slot_gap_ff);
      c_prod_ff[2] <= PROD_BITS'(d4_rem) * PROD_BITS'(slot_gap_ff);
      c_cur_ff     <= {d4_rem, d4_cur1, d4_c0};
      c_flags_ff   <= d4_flags;
   end

   // positions modulo row size
   logic                      d5_vld;
   logic [2:0][PROD_BITS-1:0] d5_quo;
   logic [2:0][GAP_BITS-1:0]  d5_rem;
   logic [2:0][SIZE_BITS-1:0] d5_cur;
   flags_type                 d5_flags;

   qspm_div #(.NW(PROD_BITS), .DW(GAP_BITS), .LANES(3),
              .SW(3 * SIZE_BITS + $bits(flags_type))) u_div_pos (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (c_vld_ff),
      .in_num   (c_prod_ff),
      .in_den   (row_slots_ff),
      .in_side  ({c_cur_ff, c_flags_ff}),
      .out_vld  (d5_vld),
      .out_quo  (d5_quo),
      .out_rem  (d5_rem),
      .out_side ({d5_cur, d5_flags})
   );

   // result sequencer
   logic                      o_act_ff;
   logic [1:0]                o_cnt_ff;
   logic [2:0][SLOT_BITS-1:0] o_pos_ff;
   logic [2:0][SIZE_BITS-1:0] o_cur_ff;
   flags_type                 o_flags_ff;
   logic                      o_single, o_final;
   logic [2:0][SLOT_BITS-1:0] pos_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         pos_in[l] = (row_slots_ff == '0) ? '0 : SLOT_BITS'({1'b0, d5_rem[l]});
      end
   end

   assign o_single = o_flags_ff.skip || (o_flags_ff.err != ERR_NONE);
   assign o_final  = o_single || (o_cnt_ff == (o_flags_ff.dims3 ? 2'd2 : 2'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         o_act_ff <= 1'b0;
         o_cnt_ff <= 2'd0;
      end else if (d5_vld) begin
         o_act_ff <= 1'b1;
         o_cnt_ff <= 2'd0;
      end else if (o_act_ff) begin
         o_act_ff <= !o_final;
         o_cnt_ff <= o_cnt_ff + 2'd1;
      end
      if (d5_vld) begin
         o_pos_ff   <= pos_in;
         o_cur_ff   <= d5_cur;
         o_flags_ff <= d5_flags;
      end
   end

   assign rsp_valid         = o_act_ff;
   assign rsp_dim_number    = o_single ? 2'd0 : o_cnt_ff;
   assign rsp_slot_position = o_single ? '0 : o_pos_ff[o_cnt_ff];
   assign rsp_entry_slot    = o_single ? '0 : o_cur_ff[o_cnt_ff];
   assign rsp_skipped       = o_flags_ff.skip;
   assign rsp_error_code    = o_flags_ff.skip ? ERR_NONE : o_flags_ff.err;
   assign rsp_last          = o_final;
endmodule
